### rtl/bfm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery fault monitor package
// Shared types, register indexes, reset values and fault codes.
// ----------------------------------------------------------------------------
package bfm_pkg;

  localparam int NUM_CELLS = 4;
  localparam int TIME_W    = 21;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [2:0] {
    REG_PCB_TEMP_MAX  = 3'd0,
    REG_CELL_TEMP_MIN = 3'd1,
    REG_CELL_TEMP_MAX = 3'd2,
    REG_CELL_MV_MIN   = 3'd3,
    REG_CELL_MV_MAX   = 3'd4,
    REG_FAULT_LIMIT   = 3'd5,
    REG_VOLT_CELLS    = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    FAULT_NONE      = 3'd0,
    FAULT_READ      = 3'd1,
    FAULT_PCB_HOT   = 3'd2,
    FAULT_CELL_COLD = 3'd3,
    FAULT_CELL_HOT  = 3'd4,
    FAULT_UNDERVOLT = 3'd5,
    FAULT_OVERVOLT  = 3'd6
  } fault_kind_t;

  localparam logic signed [7:0] RST_PCB_TEMP_MAX  = 8'sd80;
  localparam logic signed [7:0] RST_CELL_TEMP_MIN = 8'sd0;
  localparam logic signed [7:0] RST_CELL_TEMP_MAX = 8'sd45;
  localparam logic [15:0]       RST_CELL_MV_MIN   = 16'd3000;
  localparam logic [15:0]       RST_CELL_MV_MAX   = 16'd4200;
  localparam logic [19:0]       RST_FAULT_LIMIT   = 20'd5000;
  localparam logic [2:0]        RST_VOLT_CELLS    = 3'd1;

  typedef struct packed {
    logic               read_ok;
    logic signed [7:0]  pcb_temp_c;
    logic signed [7:0]  cell_temp_0;
    logic signed [7:0]  cell_temp_1;
    logic signed [7:0]  cell_temp_2;
    logic signed [7:0]  cell_temp_3;
    logic [15:0]        cell_mv_0;
    logic [15:0]        cell_mv_1;
    logic [15:0]        cell_mv_2;
    logic [15:0]        cell_mv_3;
    logic [15:0]        elapsed_ms;
  } meas_t;

  typedef struct packed {
    logic              fault_active;
    logic [2:0]        fault_kind;
    logic [1:0]        fault_cell;
    logic [TIME_W-1:0] fault_time_ms;
    logic              shutdown;
  } result_t;

  typedef struct packed {
    logic signed [7:0] pcb_temp_max_c;
    logic signed [7:0] cell_temp_min_c;
    logic signed [7:0] cell_temp_max_c;
    logic [15:0]       cell_mv_min;
    logic [15:0]       cell_mv_max;
    logic [19:0]       fault_time_limit_ms;
    logic [2:0]        voltage_cells_checked;
  } cfg_regs_t;

  typedef struct packed {
    fault_kind_t kind;
    logic [1:0]  cell_idx;
  } verdict_t;

endpackage

### rtl/bfm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery fault monitor channels
// Valid/ready interfaces for measurement requests, results and register writes.
// ----------------------------------------------------------------------------
interface bfm_meas_if;
  logic          valid;
  logic          ready;
  bfm_pkg::meas_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfm_result_if;
  logic             valid;
  logic             ready;
  bfm_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/bfm_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery fault monitor checks
// Priority evaluation of one measurement request against the thresholds.
// ----------------------------------------------------------------------------
module bfm_check (
  input  bfm_pkg::meas_t     meas,
  input  bfm_pkg::cfg_regs_t regs,
  output bfm_pkg::verdict_t  verdict
);
  import bfm_pkg::*;

  logic signed [7:0] temps [NUM_CELLS];
  logic [15:0]       mvs   [NUM_CELLS];
  logic [2:0]        nv;

  assign temps[0] = meas.cell_temp_0;
  assign mvs[0]   = meas.cell_mv_0;
  if (NUM_CELLS > 1) begin : g_c1
    assign temps[1] = meas.cell_temp_1;
    assign mvs[1]   = meas.cell_mv_1;
  end
  if (NUM_CELLS > 2) begin : g_c2
    assign temps[2] = meas.cell_temp_2;
    assign mvs[2]   = meas.cell_mv_2;
  end
  if (NUM_CELLS > 3) begin : g_c3
    assign temps[3] = meas.cell_temp_3;
    assign mvs[3]   = meas.cell_mv_3;
  end

  assign nv = (regs.voltage_cells_checked > 3'(NUM_CELLS)) ? 3'(NUM_CELLS)
                                                            : regs.voltage_cells_checked;

  always_comb begin
    verdict.kind = FAULT_NONE;
    verdict.cell_idx = 2'd0;
    if (!meas.read_ok) begin
      verdict.kind = FAULT_READ;
    end else if (meas.pcb_temp_c >= regs.pcb_temp_max_c) begin
      verdict.kind = FAULT_PCB_HOT;
    end
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (verdict.kind == FAULT_NONE) begin
        if (temps[i] < regs.cell_temp_min_c) begin
          verdict.kind = FAULT_CELL_COLD;
          verdict.cell_idx = 2'(i);
        end else if (temps[i] > regs.cell_temp_max_c) begin
          verdict.kind = FAULT_CELL_HOT;
          verdict.cell_idx = 2'(i);
        end
      end
    end
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (verdict.kind == FAULT_NONE && 3'(i) < nv) begin
        if (mvs[i] < regs.cell_mv_min) begin
          verdict.kind = FAULT_UNDERVOLT;
          verdict.cell_idx = 2'(i);
        end else if (mvs[i] > regs.cell_mv_max) begin
          verdict.kind = FAULT_OVERVOLT;
          verdict.cell_idx = 2'(i);
        end
      end
    end
  end

endmodule

### rtl/battery_fault_monitor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery fault monitor unit
// Checks each measurement round, times persisting faults and latches shutdown.
// ----------------------------------------------------------------------------
// Each accepted request's result is registered into the result buffer.
// Throughput is one request per cycle; a two-entry result buffer keeps input
// accepting while one result waits, and input stalls while two results wait.
// Synchronous reset restores all thresholds to their defaults and clears the
// fault timer, the shutdown latch and the result buffer.
module battery_fault_monitor_unit (
  input  logic  clk,
  input  logic  rst,
  bfm_meas_if.sink     meas,
  bfm_result_if.source res,
  bfm_cfg_if.sink      cfg
);
  import bfm_pkg::*;

  cfg_regs_t         regs;
  verdict_t          verdict;
  logic              pending;
  logic              pending_next;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] elapsed_next;
  logic              shut;
  logic              shut_next;
  logic [TIME_W:0]   sum;
  result_t           fresh;
  result_t           buf_q [2];
  logic [1:0]        count;
  logic              push;
  logic              pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.pcb_temp_max_c        <= RST_PCB_TEMP_MAX;
      regs.cell_temp_min_c       <= RST_CELL_TEMP_MIN;
      regs.cell_temp_max_c       <= RST_CELL_TEMP_MAX;
      regs.cell_mv_min           <= RST_CELL_MV_MIN;
      regs.cell_mv_max           <= RST_CELL_MV_MAX;
      regs.fault_time_limit_ms   <= RST_FAULT_LIMIT;
      regs.voltage_cells_checked <= RST_VOLT_CELLS;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PCB_TEMP_MAX:  regs.pcb_temp_max_c        <= cfg.data[7:0];
        REG_CELL_TEMP_MIN: regs.cell_temp_min_c       <= cfg.data[7:0];
        REG_CELL_TEMP_MAX: regs.cell_temp_max_c       <= cfg.data[7:0];
        REG_CELL_MV_MIN:   regs.cell_mv_min           <= cfg.data[15:0];
        REG_CELL_MV_MAX:   regs.cell_mv_max           <= cfg.data[15:0];
        REG_FAULT_LIMIT:   regs.fault_time_limit_ms   <= cfg.data;
        REG_VOLT_CELLS:    regs.voltage_cells_checked <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  bfm_check u_check (
    .meas    (meas.data),
    .regs    (regs),
    .verdict (verdict)
  );

  assign sum = {1'b0, elapsed} + (TIME_W+1)'(meas.data.elapsed_ms);

  always_comb begin
    pending_next = 1'b0;
    elapsed_next = '0;
    if (verdict.kind != FAULT_NONE) begin
      pending_next = 1'b1;
      if (pending) begin
        elapsed_next = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
      end
    end
    shut_next = shut ||
                (verdict.kind != FAULT_NONE &&
                 elapsed_next > TIME_W'(regs.fault_time_limit_ms));
    fresh.fault_active  = (verdict.kind != FAULT_NONE);
    fresh.fault_kind    = verdict.kind;
    fresh.fault_cell    = verdict.cell_idx;
    fresh.fault_time_ms = elapsed_next;
    fresh.shutdown      = shut_next;
  end

  assign meas.ready = (count != 2'd2);
  assign push       = meas.valid && meas.ready;
  assign pop        = res.valid && res.ready;
  assign res.valid  = (count != 2'd0);
  assign res.data   = buf_q[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      elapsed <= '0;
      shut    <= 1'b0;
      count   <= 2'd0;
    end else begin
      if (push) begin
        pending <= pending_next;
        elapsed <= elapsed_next;
        shut    <= shut_next;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      buf_q[0] <= fresh;
    end else if (pop) begin
      buf_q[0] <= buf_q[1];
    end
    if (push && count == 2'd1 && !pop) begin
      buf_q[1] <= fresh;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("Result buffer count out of range.");

  a_shut_sticky: assert property (@(posedge clk) disable iff (rst)
    shut |=> shut)
    else $error("Shutdown latch cleared without reset.");

  a_idle_timer: assert property (@(posedge clk) disable iff (rst)
    !pending |-> elapsed == '0)
    else $error("Fault timer nonzero with no pending fault.");

  a_good_result: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.data.fault_active |->
      res.data.fault_time_ms == '0 && res.data.fault_kind == FAULT_NONE)
    else $error("Good round reported with fault time or kind.");

  a_first_fault: assert property (@(posedge clk) disable iff (rst)
    push && !pending && verdict.kind != FAULT_NONE |=> elapsed == '0)
    else $error("First faulty round did not start timer at zero.");

endmodule
